/* hdl/seven_segment_scan_display_macros.svh */
// Assertion macros shared by the display controller RTL
`ifndef SEVEN_SEGMENT_SCAN_DISPLAY_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DISPLAY_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SEVSEG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SEVSEG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/sevseg_pkg.sv */
// Shared constants, types and segment decode for the seven-segment scan display
package sevseg_pkg;

   localparam int DIGIT_POSITIONS  = 8;
   localparam int MAX_SHOWN_DIGITS = 5;
   localparam int POS_W            = $clog2(DIGIT_POSITIONS);
   // start (up to 7) plus up to four more digits, compared against the 8 positions
   localparam int SUM_W            = 5;
   localparam int CNT_W            = 3;
   localparam int NUM_W            = 16;
   localparam int SEG_W            = 8;
   localparam int SEL_W            = 8;
   // floor(n / 10) == (n * 52429) >> 19 for every 16-bit n
   localparam logic [16:0] RECIP_TEN = 17'd52429;
   localparam int RECIP_SHIFT        = 19;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_SHOW = 1'b1
   } opcode_type;

   typedef enum logic {
      ST_IDLE    = 1'b0,
      ST_CONVERT = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic tick;
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_digit;
   } status_type;

   function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
      logic [SEG_W-1:0] code;
      unique case (digit)
         4'd0:    code = 8'h3f;
         4'd1:    code = 8'h06;
         4'd2:    code = 8'h5b;
         4'd3:    code = 8'h4f;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'h6d;
         4'd6:    code = 8'h7d;
         4'd7:    code = 8'h07;
         4'd8:    code = 8'h7f;
         4'd9:    code = 8'h6f;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

/* hdl/sevseg_ctrl.sv */
// Controller state machine: accepts words and sequences the decimal conversion
`include "seven_segment_scan_display_macros.svh"

module sevseg_ctrl
   import sevseg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       opcode,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (opcode == OP_SHOW)) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.tick = start && (opcode == OP_TICK);
            cmd.load = start && (opcode == OP_SHOW);
         end
         ST_CONVERT: begin
            busy     = 1'b1;
            cmd.step = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SEVSEG_ASSERT_IMPL(a_cmd_exclusive, clock, reset, 1'b1, $onehot0(cmd), "commands overlap")
   `SEVSEG_ASSERT_NEXT(a_load_busy, clock, reset, cmd.load, busy, "no conversion after load")
   `SEVSEG_ASSERT_IMPL(a_step_busy, clock, reset, cmd.step, busy && !start || busy,
      "step outside conversion")

endmodule

/* hdl/sevseg_dp.sv */
// Datapath: segment buffer, scan counter and digit-per-cycle decimal conversion
`include "seven_segment_scan_display_macros.svh"

module sevseg_dp
   import sevseg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [NUM_W-1:0] number,
   input  logic [2:0]       start_pos,
   input  logic [CNT_W-1:0] digit_count,
   output status_type       status,
   output logic             rsp_strobe,
   output logic [SEG_W-1:0] rsp_segment_byte,
   output logic [SEL_W-1:0] rsp_common_select
);

   logic [SEG_W-1:0] buf_ff [DIGIT_POSITIONS];
   logic [POS_W-1:0] scan_ff;
   logic [POS_W-1:0] scan_in;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] num_in;
   logic [SUM_W-1:0] pos_ff;
   logic [SUM_W-1:0] pos_in;
   logic [CNT_W-1:0] left_ff;
   logic [CNT_W-1:0] left_in;
   logic             strobe_ff;
   logic [SEG_W-1:0] seg_ff;
   logic [SEL_W-1:0] sel_ff;
   logic [SEL_W-1:0] sel_in;
   logic [CNT_W-1:0] count_eff;
   logic [32:0]      prod;
   logic [NUM_W-1:0] quot;
   logic [3:0]       digit;

   // digit count clamp: zero or too many means the maximum
   assign count_eff = ((digit_count == '0) || (32'(digit_count) > MAX_SHOWN_DIGITS))
                      ? CNT_W'(MAX_SHOWN_DIGITS) : digit_count;

   // one decimal digit per cycle, least significant first
   assign prod  = {16'd0, num_ff} * {16'd0, RECIP_TEN};
   assign quot  = NUM_W'(prod >> RECIP_SHIFT);
   assign digit = 4'(num_ff - ((quot << 3) + (quot << 1)));

   assign status.last_digit = (left_ff == CNT_W'(1));

   // conversion registers
   always_comb begin
      num_in  = num_ff;
      pos_in  = pos_ff;
      left_in = left_ff;
      if (cmd.load) begin
         num_in  = number;
         pos_in  = SUM_W'(start_pos) + SUM_W'(count_eff) - SUM_W'(1);
         left_in = count_eff;
      end else if (cmd.step) begin
         num_in  = quot;
         pos_in  = pos_ff - SUM_W'(1);
         left_in = left_ff - CNT_W'(1);
      end
   end

   // scan wrap and active-low common select
   always_comb begin
      scan_in = (scan_ff == POS_W'(DIGIT_POSITIONS - 1)) ? '0 : scan_ff + POS_W'(1);
      for (int k = 0; k < SEL_W; k++) begin
         sel_in[k] = (32'(scan_ff) != k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_POSITIONS; i++) begin
            buf_ff[i] <= '0;
         end
         scan_ff   <= '0;
         strobe_ff <= 1'b0;
         left_ff   <= '0;
      end else begin
         left_ff   <= left_in;
         strobe_ff <= cmd.tick;
         if (cmd.tick) begin
            scan_ff <= scan_in;
         end
         if (cmd.step && (pos_ff < SUM_W'(DIGIT_POSITIONS))) begin
            buf_ff[pos_ff[POS_W-1:0]] <= seg_code(digit);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      pos_ff <= pos_in;
      if (cmd.tick) begin
         seg_ff <= buf_ff[POS_W'(DIGIT_POSITIONS - 1) - scan_ff];
         sel_ff <= sel_in;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_segment_byte  = seg_ff;
   assign rsp_common_select = sel_ff;

   `SEVSEG_ASSERT_IMPL(a_digit_range, clock, reset, cmd.step, digit < 4'd10,
      "decimal digit out of range")
   `SEVSEG_ASSERT_NEXT(a_scan_moves, clock, reset, cmd.tick, scan_ff != $past(scan_ff),
      "scan counter did not advance")
   `SEVSEG_ASSERT_NEXT(a_scan_holds, clock, reset, !cmd.tick, $stable(scan_ff),
      "scan counter moved without tick")

endmodule

/* hdl/seven_segment_scan_display.sv */
// Tick word: result strobed in the cycle after acceptance; a tick can be accepted every
// cycle while not busy. Show word: busy after acceptance until the digit-per-cycle
// divide-by-ten unit has converted every requested digit; no word is taken meanwhile.
// Show words give no result. The receiver cannot stall; rsp_strobe lasts one cycle.
// Synchronous reset blanks all buffer entries, zeroes the scan position and clears busy.
`include "seven_segment_scan_display_macros.svh"

module seven_segment_scan_display
   import sevseg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_opcode,
   input  logic [NUM_W-1:0] req_number,
   input  logic [2:0]       req_start_pos,
   input  logic [CNT_W-1:0] req_digit_count,
   output logic             rsp_strobe,
   output logic [SEG_W-1:0] rsp_segment_byte,
   output logic [SEL_W-1:0] rsp_common_select
);

   cmd_type    cmd;
   status_type status;

   sevseg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   sevseg_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .number            (req_number),
      .start_pos         (req_start_pos),
      .digit_count       (req_digit_count),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_segment_byte  (rsp_segment_byte),
      .rsp_common_select (rsp_common_select)
   );

   `SEVSEG_ASSERT_NEXT(a_tick_result, clock, reset,
      start && !busy && (req_opcode == OP_TICK), rsp_strobe, "tick gave no result")
   `SEVSEG_ASSERT_NEXT(a_show_silent, clock, reset,
      start && !busy && (req_opcode == OP_SHOW), !rsp_strobe, "show gave a result")
   `SEVSEG_ASSERT_IMPL(a_one_select, clock, reset, rsp_strobe, $onehot0(~rsp_common_select),
      "more than one common line enabled")

endmodule

/* dv/tb_seven_segment_scan_display.sv */
// Self-checking testbench for the multiplexed seven-segment scan display controller
`timescale 1ns / 1ps

module tb_seven_segment_scan_display
   import sevseg_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 500;
   localparam int DRAIN_CYCLES   = 8;

   // common-cathode patterns for digits 0..9, bit0 = segment a
   localparam logic [SEG_W-1:0] DIGIT_PATTERN [10] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
   };

   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [SEL_W-1:0] sel;
   } scan_word_type;

   typedef struct {
      opcode_type       op;
      logic [NUM_W-1:0] num;
      logic [2:0]       spos;
      logic [CNT_W-1:0] cnt;
      bit               typed;
      logic [SEG_W-1:0] seg;
      logic [SEL_W-1:0] sel;
   } directed_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_opcode;
   logic [NUM_W-1:0] req_number;
   logic [2:0]       req_start_pos;
   logic [CNT_W-1:0] req_digit_count;
   logic             rsp_strobe;
   logic [SEG_W-1:0] rsp_segment_byte;
   logic [SEL_W-1:0] rsp_common_select;

   // predictor state: digit buffer and scan position
   logic [SEG_W-1:0] shown_codes [DIGIT_POSITIONS];
   int               scan_pos;
   scan_word_type    scan_out_q [$];

   int error_count;
   int tick_count;
   int show_count;
   int checked_count;
   int stall_cycles;

   // blank after reset, then extremes, count clamp, drop past the last position, wrap
   directed_row_type directed_rows [24] = '{
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h00, 8'hfe},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h00, 8'hfd},
      '{OP_SHOW, 16'd65535, 3'd0, 3'd5, 1'b0, 8'h00, 8'h00},
      '{OP_SHOW, 16'd0,     3'd3, 3'd0, 1'b0, 8'h00, 8'h00},
      '{OP_SHOW, 16'd12345, 3'd7, 3'd7, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h3f, 8'hfb},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h3f, 8'hf7},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h3f, 8'hef},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h6d, 8'hdf},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h6d, 8'hbf},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h7d, 8'h7f},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b1, 8'h06, 8'hfe},
      '{OP_SHOW, 16'd65535, 3'd0, 3'd2, 1'b0, 8'h00, 8'h00},
      '{OP_SHOW, 16'd9876,  3'd6, 3'd3, 1'b0, 8'h00, 8'h00},
      '{OP_SHOW, 16'd4,     3'd2, 3'd1, 1'b0, 8'h00, 8'h00},
      '{OP_SHOW, 16'd10000, 3'd4, 3'd6, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'hffff,  3'd7, 3'd7, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b0, 8'h00, 8'h00},
      '{OP_TICK, 16'd0,     3'd0, 3'd0, 1'b0, 8'h00, 8'h00}
   };

   seven_segment_scan_display u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_number        (req_number),
      .req_start_pos     (req_start_pos),
      .req_digit_count   (req_digit_count),
      .rsp_strobe        (rsp_strobe),
      .rsp_segment_byte  (rsp_segment_byte),
      .rsp_common_select (rsp_common_select)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // update the digit buffer or scan once; returns 1 when the word yields a result
   function automatic bit advance_display(input opcode_type op, input logic [NUM_W-1:0] num,
                                          input logic [2:0] spos, input logic [CNT_W-1:0] cnt,
                                          output scan_word_type word);
      int digits;
      int p;
      int weight;
      int d;
      word = '0;
      if (op == OP_SHOW) begin
         digits = (cnt == 0 || cnt > MAX_SHOWN_DIGITS) ? MAX_SHOWN_DIGITS : int'(cnt);
         for (int i = 0; i < digits; i++) begin
            p = int'(spos) + i;
            if (p >= DIGIT_POSITIONS) break;
            weight = 1;
            repeat (digits - 1 - i) weight *= 10;
            d = (int'(num) / weight) % 10;
            shown_codes[p] = DIGIT_PATTERN[d];
         end
         return 1'b0;
      end
      word.seg = shown_codes[DIGIT_POSITIONS - 1 - scan_pos];
      word.sel = ~(SEL_W'(1) << scan_pos);
      scan_pos = (scan_pos == DIGIT_POSITIONS - 1) ? 0 : scan_pos + 1;
      return 1'b1;
   endfunction

   // present one word and hold it until the block takes it
   task automatic send_word(input opcode_type op, input logic [NUM_W-1:0] num,
                            input logic [2:0] spos, input logic [CNT_W-1:0] cnt,
                            input bit typed, input logic [SEG_W-1:0] seg,
                            input logic [SEL_W-1:0] sel);
      scan_word_type predicted;
      @(negedge clock);
      start           <= 1'b1;
      req_opcode      <= op;
      req_number      <= num;
      req_start_pos   <= spos;
      req_digit_count <= cnt;
      do @(posedge clock); while (busy);
      if (advance_display(op, num, spos, cnt, predicted)) begin
         if (typed) begin
            predicted.seg = seg;
            predicted.sel = sel;
         end
         scan_out_q.push_back(predicted);
         tick_count++;
      end else begin
         show_count++;
      end
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // result checker: oldest expectation first
   always @(posedge clock) begin
      scan_word_type want;
      if (!reset && rsp_strobe) begin
         if (scan_out_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: seg %02h sel %02h",
                                      rsp_segment_byte, rsp_common_select));
         end else begin
            want = scan_out_q.pop_front();
            checked_count++;
            if (rsp_segment_byte !== want.seg)
               report_mismatch($sformatf("segment_byte got %02h want %02h",
                                         rsp_segment_byte, want.seg));
            if (rsp_common_select !== want.sel)
               report_mismatch($sformatf("common_select got %02h want %02h",
                                         rsp_common_select, want.sel));
         end
      end
   end

   // watchdog on cycles with no accepted word and no result
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", scan_out_q.size());
            $display("seven_segment_scan_display regression: fail");
            $finish;
         end
      end
   end

   initial begin
      logic [NUM_W-1:0] num;
      bit               quiet;
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = OP_TICK;
      req_number      = '0;
      req_start_pos   = '0;
      req_digit_count = '0;
      error_count     = 0;
      tick_count      = 0;
      show_count      = 0;
      checked_count   = 0;
      stall_cycles    = 0;
      scan_pos        = 0;
      foreach (shown_codes[i]) shown_codes[i] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].num, directed_rows[i].spos,
                   directed_rows[i].cnt, directed_rows[i].typed, directed_rows[i].seg,
                   directed_rows[i].sel);

      // random words, with a stretch of back-to-back traffic in the middle
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = (n >= 200 && n < 350);
         if (!quiet && $urandom_range(0, 99) < 9)
            idle_cycles($urandom_range(1, 6));
         case ($urandom_range(0, 9))
            0:       num = '0;
            1:       num = '1;
            default: num = NUM_W'($urandom_range(0, 65535));
         endcase
         if ($urandom_range(0, 99) < 55)
            send_word(OP_TICK, num, 3'($urandom), 3'($urandom), 1'b0, '0, '0);
         else
            send_word(OP_SHOW, num, 3'($urandom), 3'($urandom), 1'b0, '0, '0);
      end
      idle_cycles(1);

      // drain outstanding results, then give the block time for strays
      while (scan_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d scan ticks and %0d show words (count clamp, edge starts, wrap)",
               tick_count, show_count);
      $display("%0d segment results checked, %0d mismatches", checked_count, error_count);
      if (error_count == 0)
         $display("seven_segment_scan_display regression: pass");
      else
         $display("seven_segment_scan_display regression: fail");
      $finish;
   end

endmodule
